/* design/msc_pkg.sv */
// shared types and constants for the merge sort unit with comparison count
// no dependencies
`default_nettype none

package msc_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - COUNT_W - VALUE_W;

  typedef enum logic [1:0] {
    P_LOAD,
    P_SORT,
    P_EMIT
  } phase_t;

  typedef enum logic [1:0] {
    Q_IDLE,
    Q_WALK,
    Q_WAIT
  } seq_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_COPY,
    E_DRAIN,
    E_PRIME,
    E_MERGE
  } eng_state_t;

  typedef struct packed {
    logic done;
    logic cmp;
  } eng_status_t;

endpackage

`default_nettype wire

/* design/msc_range_seq.sv */
// range sequencer: walks the top-down split tree with a small stack and
// issues merge requests in post-order; depends on msc_pkg
`default_nettype none

module msc_range_seq #(
  parameter int unsigned MAX_ITEMS = 64,
  localparam int unsigned AW = $clog2(MAX_ITEMS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [AW-1:0]       last_idx,
  input  wire msc_pkg::eng_status_t eng_status,
  output logic                     req_valid,
  output logic [AW-1:0]            req_lo,
  output logic [AW-1:0]            req_mid,
  output logic [AW-1:0]            req_hi,
  output logic                     done
);
  import msc_pkg::*;

  localparam int unsigned SD  = 2 * AW + 2;
  localparam int unsigned SPI = $clog2(SD);
  localparam int unsigned SPW = $clog2(SD + 1);

  seq_state_t       state, state_next;
  logic [AW-1:0]    stk_lo  [SD];
  logic [AW-1:0]    stk_hi  [SD];
  logic             stk_exp [SD];
  logic [SPW-1:0]   sp;
  logic [SPI-1:0]   tp;
  logic [AW-1:0]    t_lo, t_hi, t_mid;
  logic             t_exp;
  logic             init, push2, pop;

  assign tp    = SPI'(sp - SPW'(1));
  assign t_lo  = stk_lo[tp];
  assign t_hi  = stk_hi[tp];
  assign t_exp = stk_exp[tp];
  assign t_mid = t_lo + ((t_hi - t_lo) >> 1);

  assign req_lo  = t_lo;
  assign req_mid = t_mid;
  assign req_hi  = t_hi;

  always_comb begin
    state_next = state;
    init       = 1'b0;
    push2      = 1'b0;
    pop        = 1'b0;
    req_valid  = 1'b0;
    done       = 1'b0;
    unique case (state)
      Q_IDLE: begin
        if (start) begin
          init       = 1'b1;
          state_next = Q_WALK;
        end
      end
      Q_WALK: begin
        if (sp == '0) begin
          done       = 1'b1;
          state_next = Q_IDLE;
        end else if (t_lo >= t_hi) begin
          pop = 1'b1;
        end else if (!t_exp) begin
          push2 = 1'b1;
        end else begin
          req_valid  = 1'b1;
          state_next = Q_WAIT;
        end
      end
      Q_WAIT: begin
        if (eng_status.done) begin
          pop        = 1'b1;
          state_next = Q_WALK;
        end
      end
      default: state_next = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      sp    <= '0;
    end else begin
      state <= state_next;
      if (init) begin
        sp <= SPW'(1);
      end else if (push2) begin
        sp <= sp + SPW'(2);
      end else if (pop) begin
        sp <= sp - SPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      stk_lo[0]  <= '0;
      stk_hi[0]  <= last_idx;
      stk_exp[0] <= 1'b0;
    end else if (push2) begin
      stk_exp[tp]               <= 1'b1;
      stk_lo[SPI'(tp + 1'b1)]   <= t_mid + AW'(1);
      stk_hi[SPI'(tp + 1'b1)]   <= t_hi;
      stk_exp[SPI'(tp + 1'b1)]  <= 1'b0;
      stk_lo[SPI'(tp + 2'd2)]   <= t_lo;
      stk_hi[SPI'(tp + 2'd2)]   <= t_mid;
      stk_exp[SPI'(tp + 2'd2)]  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* design/msc_engine.sv */
// merge engine: element store and merge scratch memories, copy and merge
// datapath, load and emit ports; depends on msc_pkg
`default_nettype none

module msc_engine #(
  parameter int unsigned MAX_ITEMS = 64,
  localparam int unsigned AW = $clog2(MAX_ITEMS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         ld_we,
  input  wire logic [AW-1:0]                ld_addr,
  input  wire logic [msc_pkg::VALUE_W-1:0]  ld_data,
  input  wire logic                         em_re,
  input  wire logic [AW-1:0]                em_addr,
  output logic [msc_pkg::VALUE_W-1:0]       rd_data,
  input  wire logic                         req_valid,
  input  wire logic [AW-1:0]                req_lo,
  input  wire logic [AW-1:0]                req_mid,
  input  wire logic [AW-1:0]                req_hi,
  output msc_pkg::eng_status_t              eng_status
);
  import msc_pkg::*;

  eng_state_t         state, state_next;
  logic [VALUE_W-1:0] store_mem   [MAX_ITEMS];
  logic [VALUE_W-1:0] scratch_mem [MAX_ITEMS];

  logic [AW-1:0]      lo_r, mid_r, hi_r;
  logic [AW-1:0]      c, c_next;
  logic [AW:0]        i, i_next, j, j_next;
  logic [AW-1:0]      k, k_next;
  logic               cp_wv;
  logic [AW-1:0]      cp_wa;

  logic               st_we, st_re, mg_we;
  logic [AW-1:0]      st_wa, st_ra, mg_wa;
  logic [VALUE_W-1:0] st_wd, mg_wd, st_rd;
  logic [AW-1:0]      sc_ra_a, sc_ra_b;
  logic [VALUE_W-1:0] sc_rd_a, sc_rd_b;
  logic               a_ok, b_ok, take_a, cp_re;

  assign rd_data = st_rd;

  always_comb begin
    state_next = state;
    c_next     = c;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    cp_re      = 1'b0;
    mg_we      = 1'b0;
    mg_wa      = k;
    mg_wd      = sc_rd_a;
    sc_ra_a    = i[AW-1:0];
    sc_ra_b    = j[AW-1:0];
    eng_status = '0;
    a_ok       = i <= {1'b0, mid_r};
    b_ok       = j <= {1'b0, hi_r};
    take_a     = a_ok && (!b_ok || ($signed(sc_rd_a) < $signed(sc_rd_b)));
    unique case (state)
      E_IDLE: begin
        if (req_valid) begin
          c_next     = req_lo;
          state_next = E_COPY;
        end
      end
      E_COPY: begin
        cp_re = 1'b1;
        if (c == hi_r) begin
          state_next = E_DRAIN;
        end else begin
          c_next = c + AW'(1);
        end
      end
      E_DRAIN: begin
        state_next = E_PRIME;
      end
      E_PRIME: begin
        i_next     = {1'b0, lo_r};
        j_next     = {1'b0, mid_r} + (AW+1)'(1);
        k_next     = lo_r;
        sc_ra_a    = lo_r;
        sc_ra_b    = j_next[AW-1:0];
        state_next = E_MERGE;
      end
      E_MERGE: begin
        eng_status.cmp = a_ok && b_ok;
        mg_we          = 1'b1;
        mg_wd          = take_a ? sc_rd_a : sc_rd_b;
        i_next         = i + (AW+1)'(take_a);
        j_next         = j + (AW+1)'(!take_a);
        sc_ra_a        = i_next[AW-1:0];
        sc_ra_b        = j_next[AW-1:0];
        if (k == hi_r) begin
          eng_status.done = 1'b1;
          state_next      = E_IDLE;
        end else begin
          k_next = k + AW'(1);
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  // store port sharing: load and merge writes, copy and emit reads
  always_comb begin
    st_we = ld_we || mg_we;
    st_wa = ld_we ? ld_addr : mg_wa;
    st_wd = ld_we ? ld_data : mg_wd;
    st_re = em_re || cp_re;
    st_ra = cp_re ? c : em_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      cp_wv <= 1'b0;
    end else begin
      state <= state_next;
      cp_wv <= cp_re;
    end
  end

  always_ff @(posedge clk) begin
    c     <= c_next;
    i     <= i_next;
    j     <= j_next;
    k     <= k_next;
    cp_wa <= c;
    if (state == E_IDLE && req_valid) begin
      lo_r  <= req_lo;
      mid_r <= req_mid;
      hi_r  <= req_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_rd <= store_mem[st_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cp_wv) begin
      scratch_mem[cp_wa] <= st_rd;
    end
    sc_rd_a <= scratch_mem[sc_ra_a];
    sc_rd_b <= scratch_mem[sc_ra_b];
  end

endmodule

`default_nettype wire

/* design/merge_sort_with_comparison_count_unit.sv */
// top level of the merge sort unit with comparison count: load, sort and
// emit control, output register; depends on msc_pkg, msc_range_seq, msc_engine
//
//   channel   dir  tdata                         tuser     tlast
//   s_*       in   value[31:0]                   -         final_item
//   m_*       out  sorted_value, comparison_cnt  overflow  end_of_run
//
// load takes one transaction per cycle; sorting runs the merges of the split
// tree one at a time on the engine, each merge copying its range from the store
// into the scratch memory and merging it back into the store; emit gives one
// transaction per cycle from the store read port while m_tready is high.
// s_tready is low while a set sorts or emits; m_tready low stalls emit only.
// rst clears control state; the memories are not cleared.
`default_nettype none

module merge_sort_with_comparison_count_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [msc_pkg::VALUE_W-1:0]     s_tdata,   // value
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [msc_pkg::OUT_DATA_W-1:0]       m_tdata,   // sorted_value, comparison_count
  output logic [0:0]                           m_tuser,   // overflow
  output logic                                 m_tlast
);
  import msc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  phase_t             phase, phase_next;
  logic [CW-1:0]      fill, fill_after, e;
  logic               dropped;
  logic [COUNT_W-1:0] tally;
  logic               rd_pend, rd_last;
  logic [VALUE_W-1:0] out_val;
  logic [COUNT_W-1:0] out_cnt;
  logic               out_ovf, out_last;

  logic               in_acc, has_room, ld_we, start, em_re, load_out, finish;
  logic [AW-1:0]      last_idx;
  logic [VALUE_W-1:0] rd_data;
  logic               req_valid, seq_done;
  logic [AW-1:0]      req_lo, req_mid, req_hi;
  eng_status_t        eng_status;

  assign s_tready   = (phase == P_LOAD);
  assign in_acc     = s_tvalid && s_tready;
  assign has_room   = fill < CW'(MAX_ITEMS);
  assign fill_after = has_room ? fill + CW'(1) : fill;
  assign ld_we      = in_acc && has_room;
  assign last_idx   = AW'(fill_after - CW'(1));
  assign start      = in_acc && s_tlast && (fill_after > CW'(1));
  assign load_out   = rd_pend && (!m_tvalid || m_tready);
  assign em_re      = (phase == P_EMIT) && (e < fill) && (!rd_pend || load_out);
  assign finish     = (phase == P_EMIT) && (e == fill) && !rd_pend;

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_cnt, out_val};
  assign m_tuser = out_ovf;
  assign m_tlast = out_last;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      P_LOAD: begin
        if (in_acc && s_tlast) begin
          phase_next = start ? P_SORT : P_EMIT;
        end
      end
      P_SORT: begin
        if (seq_done) begin
          phase_next = P_EMIT;
        end
      end
      P_EMIT: begin
        if (finish) begin
          phase_next = P_LOAD;
        end
      end
      default: phase_next = P_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_LOAD;
      fill     <= '0;
      dropped  <= 1'b0;
      tally    <= '0;
      e        <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (finish) begin
        fill    <= '0;
        dropped <= 1'b0;
        tally   <= '0;
        e       <= '0;
      end else begin
        if (in_acc) begin
          fill <= fill_after;
          if (!has_room) begin
            dropped <= 1'b1;
          end
        end
        if (eng_status.cmp) begin
          tally <= tally + COUNT_W'(1);
        end
        if (em_re) begin
          e <= e + CW'(1);
        end
      end
      if (em_re) begin
        rd_pend <= 1'b1;
      end else if (load_out) begin
        rd_pend <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em_re) begin
      rd_last <= (e == fill - CW'(1));
    end
    if (load_out) begin
      out_val  <= rd_data;
      out_cnt  <= tally;
      out_ovf  <= dropped;
      out_last <= rd_last;
    end
  end

  msc_range_seq #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_idx   (last_idx),
    .eng_status (eng_status),
    .req_valid  (req_valid),
    .req_lo     (req_lo),
    .req_mid    (req_mid),
    .req_hi     (req_hi),
    .done       (seq_done)
  );

  msc_engine #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .ld_we      (ld_we),
    .ld_addr    (fill[AW-1:0]),
    .ld_data    (s_tdata),
    .em_re      (em_re),
    .em_addr    (e[AW-1:0]),
    .rd_data    (rd_data),
    .req_valid  (req_valid),
    .req_lo     (req_lo),
    .req_mid    (req_mid),
    .req_hi     (req_hi),
    .eng_status (eng_status)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_cmp_in_sort: assert property (@(posedge clk) disable iff (rst)
    eng_status.cmp |-> phase == P_SORT)
    else $error("comparison outside sort phase");

  a_pend_in_emit: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> phase == P_EMIT)
    else $error("store read pending outside emit phase");

  a_tally_hold: assert property (@(posedge clk) disable iff (rst)
    (phase == P_EMIT) |=> (phase != P_EMIT) || $stable(tally))
    else $error("comparison count changed during emit");
`endif

endmodule

`default_nettype wire
